// File: sv/ppid_pkg.sv
`timescale 1ns / 1ps
// Package for the positional PID regulator: field widths, register
// indexes and the configuration struct. No dependencies.
package ppid_pkg;

   localparam int DataWidth    = 32;
   localparam int LimitWidth   = 31;
   localparam int CsrIdxWidth  = 2;
   localparam int ProdWidth    = 2 * DataWidth;
   localparam int QShift       = 16;
   localparam int TermWidth    = ProdWidth - QShift;
   localparam int IntegWidth   = 48;
   localparam int SumWidth     = 50;

   localparam logic signed [DataWidth-1:0] PropGainReset    = 32'sd9830;
   localparam logic signed [DataWidth-1:0] IntegGainReset   = 32'sd0;
   localparam logic signed [DataWidth-1:0] DerivGainReset   = 32'sd0;
   localparam logic [LimitWidth-1:0]       OutLimitReset    = 31'd393216;

   typedef enum logic [CsrIdxWidth-1:0] {
      REG_PROP_GAIN     = 2'd0,
      REG_INTEG_GAIN_TS = 2'd1,
      REG_DERIV_GAIN_TS = 2'd2,
      REG_OUT_LIMIT     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] prop_gain;
      logic signed [DataWidth-1:0] integ_gain_ts;
      logic signed [DataWidth-1:0] deriv_gain_ts;
      logic [LimitWidth-1:0]       out_limit;
   } gains_type;

endpackage

// File: sv/ppid_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for samples, results and register writes.
// Depends on ppid_pkg for the field widths.
interface ppid_req_if import ppid_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [DataWidth-1:0] measured;
   logic signed [DataWidth-1:0] setpoint;
   modport source (output valid, output measured, output setpoint, input ready);
   modport sink (input valid, input measured, input setpoint, output ready);
endinterface

interface ppid_rsp_if import ppid_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [DataWidth-1:0] drive;
   logic                        clamped;
   modport source (output valid, output drive, output clamped, input ready);
   modport sink (input valid, input drive, input clamped, output ready);
endinterface

interface ppid_csr_if import ppid_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CsrIdxWidth-1:0] index;
   logic [DataWidth-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/ppid_csr.sv
`timescale 1ns / 1ps
// Configuration register file for the PID regulator: gains and output limit.
// Depends on ppid_pkg and the ppid_csr_if interface.
module ppid_csr import ppid_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ppid_csr_if.sink    csr_bus,
   output gains_type   gains
);

   gains_type gains_ff;
   gains_type gains_in;

   assign csr_bus.ready = 1'b1;
   assign gains = gains_ff;

   always_comb begin
      gains_in = gains_ff;
      if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.index))
            REG_PROP_GAIN:     gains_in.prop_gain     = csr_bus.data;
            REG_INTEG_GAIN_TS: gains_in.integ_gain_ts = csr_bus.data;
            REG_DERIV_GAIN_TS: gains_in.deriv_gain_ts = csr_bus.data;
            REG_OUT_LIMIT:     gains_in.out_limit     = csr_bus.data[LimitWidth-1:0];
            default:           gains_in = gains_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.prop_gain     <= PropGainReset;
         gains_ff.integ_gain_ts <= IntegGainReset;
         gains_ff.deriv_gain_ts <= DerivGainReset;
         gains_ff.out_limit     <= OutLimitReset;
      end else begin
         gains_ff <= gains_in;
      end
   end

endmodule

// File: sv/ppid_core.sv
`timescale 1ns / 1ps
// PID datapath: sample register, single-pass error/P/I/D/clamp logic,
// integrator and last-error state, and result register. Uses ppid_pkg.
module ppid_core import ppid_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  gains_type   gains,
   ppid_req_if.sink    req_bus,
   ppid_rsp_if.source  rsp_bus
);

   logic                         in_valid_ff;
   logic signed [DataWidth-1:0]  meas_ff;
   logic signed [DataWidth-1:0]  setp_ff;
   logic                         out_valid_ff;
   logic signed [DataWidth-1:0]  drive_ff;
   logic                         clamped_ff;
   logic signed [IntegWidth-1:0] integ_ff;
   logic signed [IntegWidth-1:0] integ_in;
   logic signed [DataWidth-1:0]  prev_err_ff;

   logic                         advance;
   logic                         fire;
   logic signed [DataWidth:0]    err_wide;
   logic signed [DataWidth-1:0]  err;
   logic signed [DataWidth:0]    diff_wide;
   logic signed [DataWidth-1:0]  diff;
   logic signed [ProdWidth-1:0]  p_prod;
   logic signed [ProdWidth-1:0]  i_prod;
   logic signed [ProdWidth-1:0]  d_prod;
   logic signed [TermWidth-1:0]  p_term;
   logic signed [TermWidth-1:0]  i_term;
   logic signed [TermWidth-1:0]  d_term;
   logic signed [IntegWidth:0]   integ_wide;
   logic signed [SumWidth-1:0]   sum;
   logic signed [SumWidth-1:0]   lim_pos;
   logic signed [SumWidth-1:0]   lim_neg;
   logic signed [DataWidth-1:0]  drive_in;
   logic                         clamped_in;

   function automatic logic signed [DataWidth-1:0] sat_data(
      input logic signed [DataWidth:0] x
   );
      logic signed [DataWidth-1:0] r;
      if (x[DataWidth] != x[DataWidth-1]) begin
         r = x[DataWidth] ? {1'b1, {(DataWidth-1){1'b0}}} : {1'b0, {(DataWidth-1){1'b1}}};
      end else begin
         r = x[DataWidth-1:0];
      end
      return r;
   endfunction

   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign fire          = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;

   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.drive   = drive_ff;
   assign rsp_bus.clamped = clamped_ff;

   always_comb begin
      err_wide  = {setp_ff[DataWidth-1], setp_ff} - {meas_ff[DataWidth-1], meas_ff};
      err       = sat_data(err_wide);
      diff_wide = {err[DataWidth-1], err} - {prev_err_ff[DataWidth-1], prev_err_ff};
      diff      = sat_data(diff_wide);

      p_prod = gains.prop_gain * err;
      i_prod = gains.integ_gain_ts * err;
      d_prod = gains.deriv_gain_ts * diff;
      p_term = p_prod[ProdWidth-1:QShift];
      i_term = i_prod[ProdWidth-1:QShift];
      d_term = d_prod[ProdWidth-1:QShift];

      integ_wide = {i_term[TermWidth-1], i_term} + {integ_ff[IntegWidth-1], integ_ff};
      if (integ_wide[IntegWidth] != integ_wide[IntegWidth-1]) begin
         integ_in = integ_wide[IntegWidth] ? {1'b1, {(IntegWidth-1){1'b0}}}
                                           : {1'b0, {(IntegWidth-1){1'b1}}};
      end else begin
         integ_in = integ_wide[IntegWidth-1:0];
      end

      sum = SumWidth'(p_term) + SumWidth'(integ_in) + SumWidth'(d_term);
      lim_pos = {{(SumWidth-LimitWidth){1'b0}}, gains.out_limit};
      lim_neg = -lim_pos;

      if (sum > lim_pos) begin
         drive_in   = lim_pos[DataWidth-1:0];
         clamped_in = 1'b1;
      end else if (sum < lim_neg) begin
         drive_in   = lim_neg[DataWidth-1:0];
         clamped_in = 1'b1;
      end else begin
         drive_in   = sum[DataWidth-1:0];
         clamped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         integ_ff     <= '0;
         prev_err_ff  <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         if (fire) begin
            out_valid_ff <= 1'b1;
            integ_ff     <= integ_in;
            prev_err_ff  <= err;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         meas_ff <= req_bus.measured;
         setp_ff <= req_bus.setpoint;
      end
      if (fire) begin
         drive_ff   <= drive_in;
         clamped_ff <= clamped_in;
      end
   end

endmodule

// File: sv/positional_pid_with_clamp.sv
`timescale 1ns / 1ps
// Top level of the positional PID regulator with output clamp.
// Depends on ppid_pkg, the ppid interfaces, ppid_csr and ppid_core.
//
// Usage: each beat on req_bus carries one measured value and one setpoint,
// both signed Q16.16. Each accepted beat yields exactly one beat on rsp_bus
// with the clamped drive value and a flag that is set when the limit applied.
// Gains and the output limit are written through csr_bus, which is always
// ready; index 0 is kp, 1 is ki*Ts, 2 is kd/Ts and 3 is the limit magnitude.
// Write them only while no sample is in flight.
// An accepted request beat is held in the sample register, then passes
// through the arithmetic into the result register, where it stands as a
// valid response beat. Throughput is one sample per cycle while rsp_bus.ready
// is high; the limit is the integrator and last-error feedback, which closes through the single-pass arithmetic.
// When the receiver holds rsp_bus.ready low, the result stays registered and
// one more sample is taken into the sample register before req_bus.ready
// drops. Reset clears the integrator and last error, empties both
// registers and loads kp = 9830, ki*Ts = 0, kd/Ts = 0 and a limit of 6.0.
module positional_pid_with_clamp import ppid_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ppid_req_if.sink    req_bus,
   ppid_rsp_if.source  rsp_bus,
   ppid_csr_if.sink    csr_bus
);

   gains_type gains;

   ppid_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .gains   (gains)
   );

   ppid_core u_core (
      .clock   (clock),
      .reset   (reset),
      .gains   (gains),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

endmodule
